FILE: hw/rtl/quadrature_counter_velocity_filter_unit_assert.svh
// Assertion macros shared by the encoder counter RTL.
`ifndef QUADRATURE_COUNTER_VELOCITY_FILTER_UNIT_ASSERT_SVH
`define QUADRATURE_COUNTER_VELOCITY_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define QCVF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define QCVF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/qcvf_pkg.sv
// Types and constants of the quadrature counter with velocity filter.
package qcvf_pkg;

    localparam int POS_W = 32;
    localparam int TOT_W = 48;
    localparam int SMO_W = 40;
    localparam int CFG_W = 11;
    localparam int REQ_W = 2;
    localparam int CHN_W = 2;
    localparam int SUM_W = TOT_W + 2;
    localparam int CNT_W = $clog2(TOT_W);

    localparam logic signed [TOT_W-1:0] TOTAL_MAX = {1'b0, {(TOT_W-1){1'b1}}};
    localparam logic signed [TOT_W-1:0] TOTAL_MIN = {1'b1, {(TOT_W-1){1'b0}}};
    localparam logic signed [TOT_W-1:0] SMOOTH_MAX =
        {{(TOT_W-SMO_W+1){1'b0}}, {(SMO_W-1){1'b1}}};
    localparam logic signed [TOT_W-1:0] SMOOTH_MIN =
        {{(TOT_W-SMO_W+1){1'b1}}, {(SMO_W-1){1'b0}}};

    typedef enum logic [REQ_W-1:0] {
        REQ_EDGE_A = 2'd0,
        REQ_EDGE_B = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_SAMPLE = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV1,
        S_DIV2,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0]        pos;
        logic [POS_W-1:0]        last;
        logic                    exp_a;
        logic                    exp_b;
        logic signed [TOT_W-1:0] total;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic                    start;
        logic signed [TOT_W-1:0] dividend;
        logic [CFG_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [TOT_W-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: hw/rtl/qcvf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qcvf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/qcvf_div.sv
// Radix-2 restoring divider: signed 48-bit dividend by unsigned 11-bit divisor.
module qcvf_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qcvf_pkg::t_div_req  i_req,
    output qcvf_pkg::t_div_rsp  o_rsp
);

    logic                             r_busy;
    logic                             r_fix;
    logic                             r_done;
    logic                             r_neg;
    logic [qcvf_pkg::CNT_W-1:0]       r_cnt;
    logic [qcvf_pkg::CFG_W-1:0]       r_div;
    logic [qcvf_pkg::CFG_W-1:0]       r_rem;
    logic [qcvf_pkg::TOT_W-1:0]       r_quo;
    logic signed [qcvf_pkg::TOT_W-1:0] r_quot_out;

    logic [qcvf_pkg::CFG_W:0]         trial;
    logic                             ge;
    logic [qcvf_pkg::CFG_W:0]         diff;

    always_comb begin
        trial = {r_rem, r_quo[qcvf_pkg::TOT_W-1]};
        ge    = (trial >= {1'b0, r_div});
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fix;
            r_fix  <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == qcvf_pkg::CNT_W'(qcvf_pkg::TOT_W - 1))) begin
                r_busy <= 1'b0;
                r_fix  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            // work on the magnitude, put the sign back at the end
            r_quo <= i_req.dividend[qcvf_pkg::TOT_W-1] ? -i_req.dividend : i_req.dividend;
            r_neg <= i_req.dividend[qcvf_pkg::TOT_W-1];
            r_div <= i_req.divisor;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[qcvf_pkg::CFG_W-1:0] : trial[qcvf_pkg::CFG_W-1:0];
            r_quo <= {r_quo[qcvf_pkg::TOT_W-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_fix) begin
            r_quot_out <= r_neg ? -$signed(r_quo) : $signed(r_quo);
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quot_out;

`include "quadrature_counter_velocity_filter_unit_assert.svh"

    `QCVF_ASSERT_IMPLIES(a_no_restart, i_req.start, !r_busy && !r_fix, "divider restarted while busy")
    `QCVF_ASSERT_IMPLIES(a_done_after_fix, o_rsp.done, $past(r_fix), "done without sign fix")
    `QCVF_ASSERT_IMPLIES(a_fix_not_busy, r_fix, !r_busy, "sign fix overlaps iteration")

endmodule

FILE: hw/rtl/quadrature_counter_velocity_filter_unit.sv
// Encoder, clear and out-of-range beats: S_READ then S_OUT; the next beat is accepted back in S_IDLE.
// Sample beats: S_READ, S_DIV1, S_DIV2, S_OUT, with two passes through the shared 48-step divider.
// Output register lets the next beat be accepted while a result waits downstream.
// i_rst_n (synchronous, active low) clears the sequencer, the per-channel valid bits
// (an unwritten channel reads as all zero) and sets the divisor to 1; no clearing pass.
module quadrature_counter_velocity_filter_unit #(
    parameter int CHANNELS  = 3,
    parameter int FRAC_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [qcvf_pkg::CFG_W-1:0]       i_cfg_wr_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [qcvf_pkg::REQ_W-1:0]       i_req_type,
    input  logic [qcvf_pkg::CHN_W-1:0]       i_channel,
    input  logic                             i_level_a,
    input  logic                             i_level_b,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [qcvf_pkg::POS_W-1:0] o_count_now,
    output logic signed [qcvf_pkg::POS_W-1:0] o_speed_raw,
    output logic signed [qcvf_pkg::SMO_W-1:0] o_speed_smoothed
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    qcvf_pkg::t_state r_state, n_state;
    qcvf_pkg::t_req   r_req;
    logic [AW-1:0]    r_idx;
    logic             r_chan_ok;
    logic             r_la, r_lb;
    logic             r_rd_vld;
    logic [CHANNELS-1:0] r_vld;
    logic [qcvf_pkg::CFG_W-1:0] r_cfg;

    qcvf_pkg::t_entry r_hold, n_hold;
    logic [qcvf_pkg::POS_W-1:0]        r_dv, n_dv;
    logic signed [qcvf_pkg::TOT_W-1:0] r_tot, n_tot;
    logic [qcvf_pkg::POS_W-1:0]        r_res_count, n_res_count;
    logic [qcvf_pkg::POS_W-1:0]        r_res_raw, n_res_raw;
    logic [qcvf_pkg::SMO_W-1:0]        r_res_smooth, n_res_smooth;

    logic                              r_out_valid;
    logic [qcvf_pkg::POS_W-1:0]        r_out_count, r_out_raw;
    logic [qcvf_pkg::SMO_W-1:0]        r_out_smooth;

    logic             accept;
    logic             in_chan_ok;
    logic [AW-1:0]    in_idx;
    logic             out_free;
    logic             out_load;

    logic [qcvf_pkg::ENTRY_W-1:0] ram_rd_data;
    logic                         ram_we;
    qcvf_pkg::t_entry             rd_entry, wr_entry;

    qcvf_pkg::t_div_req div_req;
    qcvf_pkg::t_div_rsp div_rsp;
    logic [qcvf_pkg::CFG_W-1:0] div_n;

    logic signed [qcvf_pkg::POS_W-1:0] dv_s;
    logic signed [qcvf_pkg::SUM_W-1:0] vel_sh;
    logic signed [qcvf_pkg::SUM_W-1:0] sum;
    logic signed [qcvf_pkg::TOT_W-1:0] tot_sat;
    logic signed [qcvf_pkg::TOT_W-1:0] q_sat;

    assign in_chan_ok = (32'(i_channel) < 32'(CHANNELS));
    assign in_idx     = AW'(i_channel);
    assign accept     = i_in_valid && (r_state == qcvf_pkg::S_IDLE);
    assign o_in_stall = (r_state != qcvf_pkg::S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign div_n      = (r_cfg == '0) ? qcvf_pkg::CFG_W'(1) : r_cfg;

    qcvf_ram #(
        .WIDTH (qcvf_pkg::ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_idx),
        .i_wr_data (wr_entry),
        .i_rd_en   (accept),
        .i_rd_addr (in_idx),
        .o_rd_data (ram_rd_data)
    );

    qcvf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // filter update: total + (vel << FRAC_BITS) - total / N, saturated to 48 bits
    always_comb begin
        dv_s   = $signed(r_dv);
        vel_sh = qcvf_pkg::SUM_W'(dv_s) <<< FRAC_BITS;
        sum    = qcvf_pkg::SUM_W'(r_tot) + vel_sh - qcvf_pkg::SUM_W'(div_rsp.quotient);
        if (sum > qcvf_pkg::SUM_W'(qcvf_pkg::TOTAL_MAX)) begin
            tot_sat = qcvf_pkg::TOTAL_MAX;
        end else if (sum < qcvf_pkg::SUM_W'(qcvf_pkg::TOTAL_MIN)) begin
            tot_sat = qcvf_pkg::TOTAL_MIN;
        end else begin
            tot_sat = sum[qcvf_pkg::TOT_W-1:0];
        end
        if (div_rsp.quotient > qcvf_pkg::SMOOTH_MAX) begin
            q_sat = qcvf_pkg::SMOOTH_MAX;
        end else if (div_rsp.quotient < qcvf_pkg::SMOOTH_MIN) begin
            q_sat = qcvf_pkg::SMOOTH_MIN;
        end else begin
            q_sat = div_rsp.quotient;
        end
    end

    always_comb begin
        rd_entry     = r_rd_vld ? qcvf_pkg::t_entry'(ram_rd_data) : '0;
        n_state      = r_state;
        n_hold       = r_hold;
        n_dv         = r_dv;
        n_tot        = r_tot;
        n_res_count  = r_res_count;
        n_res_raw    = r_res_raw;
        n_res_smooth = r_res_smooth;
        wr_entry     = rd_entry;
        ram_we       = 1'b0;
        out_load     = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = rd_entry.total;
        div_req.divisor  = div_n;

        case (r_state)
            qcvf_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = qcvf_pkg::S_READ;
                end
            end
            qcvf_pkg::S_READ: begin
                n_hold       = rd_entry;
                n_res_count  = '0;
                n_res_raw    = '0;
                n_res_smooth = '0;
                n_state      = qcvf_pkg::S_OUT;
                if (r_chan_ok) begin
                    case (r_req)
                        qcvf_pkg::REQ_EDGE_A: begin
                            if (r_la && r_lb && rd_entry.exp_a) begin
                                wr_entry.pos   = rd_entry.pos - 1'b1;
                                wr_entry.exp_a = 1'b0;
                                wr_entry.exp_b = 1'b0;
                            end else if (r_la && !r_lb) begin
                                wr_entry.exp_b = 1'b1;
                            end
                            ram_we      = 1'b1;
                            n_res_count = wr_entry.pos;
                        end
                        qcvf_pkg::REQ_EDGE_B: begin
                            if (r_la && r_lb && rd_entry.exp_b) begin
                                wr_entry.pos   = rd_entry.pos + 1'b1;
                                wr_entry.exp_a = 1'b0;
                                wr_entry.exp_b = 1'b0;
                            end else if (r_lb && !r_la) begin
                                wr_entry.exp_a = 1'b1;
                            end
                            ram_we      = 1'b1;
                            n_res_count = wr_entry.pos;
                        end
                        qcvf_pkg::REQ_CLEAR: begin
                            wr_entry.pos = '0;
                            ram_we       = 1'b1;
                        end
                        qcvf_pkg::REQ_SAMPLE: begin
                            n_dv          = rd_entry.pos - rd_entry.last;
                            n_tot         = rd_entry.total;
                            div_req.start = 1'b1;
                            n_state       = qcvf_pkg::S_DIV1;
                        end
                        default: begin
                            n_state = qcvf_pkg::S_OUT;
                        end
                    endcase
                end
            end
            qcvf_pkg::S_DIV1: begin
                div_req.dividend = tot_sat;
                if (div_rsp.done) begin
                    n_tot         = tot_sat;
                    div_req.start = 1'b1;
                    n_state       = qcvf_pkg::S_DIV2;
                end
            end
            qcvf_pkg::S_DIV2: begin
                wr_entry      = r_hold;
                wr_entry.last = r_hold.pos;
                wr_entry.total = r_tot;
                if (div_rsp.done) begin
                    ram_we       = 1'b1;
                    n_res_count  = r_hold.pos;
                    n_res_raw    = r_dv;
                    n_res_smooth = q_sat[qcvf_pkg::SMO_W-1:0];
                    n_state      = qcvf_pkg::S_OUT;
                end
            end
            qcvf_pkg::S_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = qcvf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = qcvf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qcvf_pkg::S_IDLE;
            r_vld       <= '0;
            r_cfg       <= qcvf_pkg::CFG_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (ram_we) begin
                r_vld[r_idx] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req     <= qcvf_pkg::t_req'(i_req_type);
            r_idx     <= in_idx;
            r_chan_ok <= in_chan_ok;
            r_la      <= i_level_a;
            r_lb      <= i_level_b;
            // unwritten channels read as zero
            r_rd_vld  <= in_chan_ok ? r_vld[in_idx] : 1'b0;
        end
        r_hold       <= n_hold;
        r_dv         <= n_dv;
        r_tot        <= n_tot;
        r_res_count  <= n_res_count;
        r_res_raw    <= n_res_raw;
        r_res_smooth <= n_res_smooth;
        if (out_load) begin
            r_out_count  <= r_res_count;
            r_out_raw    <= r_res_raw;
            r_out_smooth <= r_res_smooth;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_count_now      = $signed(r_out_count);
    assign o_speed_raw      = $signed(r_out_raw);
    assign o_speed_smoothed = $signed(r_out_smooth);

`include "quadrature_counter_velocity_filter_unit_assert.svh"

    `QCVF_ASSERT_IMPLIES(a_div_start_state, div_req.start, r_state == qcvf_pkg::S_READ || r_state == qcvf_pkg::S_DIV1, "divider started outside sample flow")
    `QCVF_ASSERT_IMPLIES(a_div_done_state, div_rsp.done, r_state == qcvf_pkg::S_DIV1 || r_state == qcvf_pkg::S_DIV2, "divider result with nobody waiting")
    `QCVF_ASSERT_IMPLIES(a_wr_in_range, ram_we, r_chan_ok && (r_state == qcvf_pkg::S_READ || r_state == qcvf_pkg::S_DIV2), "state write for bad channel or state")
    `QCVF_ASSERT_NEXT(a_out_loaded, out_load, o_out_valid && r_state == qcvf_pkg::S_IDLE, "result not presented after load")

endmodule
